@@ hdl/sv39ptw_pkg.sv @@
// Shared types and constants of the Sv39 page table walker.
package sv39ptw_pkg;

	localparam int unsigned VA_W      = 64;
	localparam int unsigned HELD_VA_W = 39;
	localparam int unsigned ROOT_W    = 44;
	localparam int unsigned MODE_W    = 4;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 64;
	localparam int unsigned VPN_W     = 9;
	localparam int unsigned OFFSET_W  = 12;

	// address mode codes
	localparam logic [MODE_W-1:0] MODE_DIRECT   = 4'd0;
	localparam logic [MODE_W-1:0] MODE_SV39     = 4'd8;
	localparam logic [MODE_W-1:0] MODE_SV39_ALT = 4'd9;

	// input item opcodes
	localparam logic OP_REQUEST  = 1'b0;
	localparam logic OP_RESPONSE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_PAGE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADDR_MODE = 1'd1;

	// walk levels
	localparam logic [1:0] LEVEL_ROOT = 2'd2;
	localparam logic [1:0] LEVEL_MID  = 2'd1;
	localparam logic [1:0] LEVEL_LEAF = 2'd0;

	typedef enum logic [1:0] {
		KIND_READ   = 2'd0,
		KIND_DONE   = 2'd1,
		KIND_FAULT  = 2'd2,
		KIND_DIRECT = 2'd3
	} kind_t;

	typedef struct packed {
		logic                 busy;
		logic [1:0]           level;
		logic [HELD_VA_W-1:0] va;
	} walk_state_t;

	typedef struct packed {
		logic          valid;
		kind_t         kind;
		logic [VA_W-1:0] address;
	} walk_result_t;

endpackage

@@ hdl/sv39ptw_ifs.sv @@
// Channel interfaces of the Sv39 page table walker.
interface sv39ptw_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [63:0] virtual_address;
	logic [63:0] entry_data;

	modport source (output valid, mode, virtual_address, entry_data, input ready);
	modport sink   (input valid, mode, virtual_address, entry_data, output ready);
endinterface

interface sv39ptw_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [63:0] address;

	modport source (output valid, kind, address, input ready);
	modport sink   (input valid, kind, address, output ready);
endinterface

interface sv39ptw_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/sv39ptw_step.sv @@
// Next-state and result logic for one walker beat.
module sv39ptw_step (
	input  sv39ptw_pkg::walk_state_t            state,
	input  logic [sv39ptw_pkg::ROOT_W-1:0]      root_page_number,
	input  logic [sv39ptw_pkg::MODE_W-1:0]      address_mode,
	input  logic                                mode,
	input  logic [sv39ptw_pkg::VA_W-1:0]        virtual_address,
	input  logic [63:0]                         entry_data,
	output sv39ptw_pkg::walk_state_t            next_state,
	output sv39ptw_pkg::walk_result_t           result
);

	logic [1:0]                       next_level;
	logic [sv39ptw_pkg::VPN_W-1:0]    vpn;
	logic [43:0]                      entry_ppn;

	assign next_level = state.level - 2'd1;
	assign entry_ppn  = entry_data[53:10];

	// pick the vpn for the level about to be read
	always_comb begin
		case (next_level)
			sv39ptw_pkg::LEVEL_LEAF: vpn = state.va[20:12];
			sv39ptw_pkg::LEVEL_MID:  vpn = state.va[29:21];
			default:                 vpn = state.va[38:30];
		endcase
	end

	always_comb begin
		next_state     = state;
		result.valid   = 1'b0;
		result.kind    = sv39ptw_pkg::KIND_FAULT;
		result.address = '0;
		if (mode == sv39ptw_pkg::OP_REQUEST) begin
			if (!state.busy) begin
				result.valid = 1'b1;
				if (address_mode == sv39ptw_pkg::MODE_DIRECT) begin
					result.kind    = sv39ptw_pkg::KIND_DIRECT;
					result.address = virtual_address;
				end else if (address_mode == sv39ptw_pkg::MODE_SV39 ||
						address_mode == sv39ptw_pkg::MODE_SV39_ALT) begin
					next_state.busy  = 1'b1;
					next_state.level = sv39ptw_pkg::LEVEL_ROOT;
					next_state.va    = virtual_address[sv39ptw_pkg::HELD_VA_W-1:0];
					result.kind      = sv39ptw_pkg::KIND_READ;
					result.address   = {8'd0, root_page_number, virtual_address[38:30], 3'd0};
				end
			end
		end else if (state.busy) begin
			result.valid = 1'b1;
			if (!entry_data[0]) begin
				next_state.busy  = 1'b0;
				next_state.level = sv39ptw_pkg::LEVEL_LEAF;
			end else if (state.level != sv39ptw_pkg::LEVEL_LEAF) begin
				next_state.level = next_level;
				result.kind      = sv39ptw_pkg::KIND_READ;
				result.address   = {8'd0, entry_ppn, vpn, 3'd0};
			end else begin
				next_state.busy = 1'b0;
				result.kind     = sv39ptw_pkg::KIND_DONE;
				result.address  = {8'd0, entry_ppn, state.va[sv39ptw_pkg::OFFSET_W-1:0]};
			end
		end
	end

endmodule

@@ hdl/sv39_page_table_walker.sv @@
// Top level of the Sv39 page table walker.
//
// Three-level Sv39 page table walker. Each input beat is either a translate
// request or a page table entry read response; it is accepted whenever the
// result register is empty or being emptied in the same cycle, so one beat
// can be taken every clock while the result side keeps up, and the result
// of a beat is registered once and shown in the next cycle. A request
// with address mode 0 returns the address unchanged (direct), modes 8 and 9
// start a walk and return the root read address, any other mode returns a
// fault with address 0. Each valid entry response returns the next read
// address, or at the leaf the physical address; an entry with bit 0 clear
// ends the walk with a fault. A request while a walk runs, or a response
// while idle, is consumed without a result. There are no permission or
// superpage checks. Configuration writes are always accepted; write them
// only while the walker is idle.
module sv39_page_table_walker (
	input  logic                  clk,
	input  logic                  arst_n,
	sv39ptw_in_if.sink            item_ch,
	sv39ptw_out_if.source         result_ch,
	sv39ptw_cfg_if.sink           cfg
);

	// configuration registers
	logic [sv39ptw_pkg::ROOT_W-1:0] root_page_q;
	logic [sv39ptw_pkg::MODE_W-1:0] addr_mode_q;

	// walk state and result register
	sv39ptw_pkg::walk_state_t  state_q;
	sv39ptw_pkg::walk_state_t  state_next;
	sv39ptw_pkg::walk_result_t step_result;
	logic                      out_valid_q;
	sv39ptw_pkg::kind_t        out_kind_q;
	logic [63:0]               out_addr_q;
	logic                      in_beat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_page_q <= '0;
			addr_mode_q <= sv39ptw_pkg::MODE_DIRECT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sv39ptw_pkg::REG_ROOT_PAGE: root_page_q <= cfg.data[sv39ptw_pkg::ROOT_W-1:0];
				sv39ptw_pkg::REG_ADDR_MODE: addr_mode_q <= cfg.data[sv39ptw_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// take a new beat whenever the result slot will be free
	assign item_ch.ready = !out_valid_q || result_ch.ready;
	assign in_beat       = item_ch.valid && item_ch.ready;

	sv39ptw_step u_step (
		.state            (state_q),
		.root_page_number (root_page_q),
		.address_mode     (addr_mode_q),
		.mode             (item_ch.mode),
		.virtual_address  (item_ch.virtual_address),
		.entry_data       (item_ch.entry_data),
		.next_state       (state_next),
		.result           (step_result)
	);

	// advance walk state on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (in_beat) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_beat) begin
			out_valid_q <= step_result.valid;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold payload until the result beat is taken
	always_ff @(posedge clk) begin
		if (in_beat) begin
			out_kind_q <= step_result.kind;
			out_addr_q <= step_result.address;
		end
	end

	assign result_ch.valid   = out_valid_q;
	assign result_ch.kind    = out_kind_q;
	assign result_ch.address = out_addr_q;

endmodule

@@ tb/sv/sv39_page_table_walker_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the Sv39 page table walker: directed and random walks.
module sv39_page_table_walker_test;
	import sv39ptw_pkg::*;

	localparam int unsigned IDLE_PCT       = 21;    // chance in a hundred of a bubble
	localparam int unsigned SETTLE_CYCLES  = 3;     // margin for the result register to settle
	localparam int unsigned WATCHDOG_LIMIT = 1000;  // cycles with no beat moving anywhere
	localparam logic [63:0] ENTRY_PPN_MASK = 64'h003f_ffff_ffff_fc00;
	localparam logic [ROOT_W-1:0] ROOT_MAX = '1;

	// one result beat as the walker should present it
	typedef struct packed {
		kind_t       kind;
		logic [63:0] address;
	} walk_beat_t;

	logic clk;
	logic arst_n;

	sv39ptw_in_if  walk_in ();
	sv39ptw_out_if walk_out ();
	sv39ptw_cfg_if walk_cfg ();

	sv39_page_table_walker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_ch   (walk_in),
		.result_ch (walk_out),
		.cfg       (walk_cfg)
	);

	// Shadow copy of the walker: its registers and its walk state.
	logic [ROOT_W-1:0]    root_page;
	logic [MODE_W-1:0]    addr_mode;
	logic                 walk_busy;
	logic [1:0]           walk_level;
	logic [HELD_VA_W-1:0] held_va;

	walk_beat_t  expected_results[$];
	int unsigned mismatches;
	int unsigned quiet_cycles;
	bit          no_stall;

	always #10 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Byte offset of the page table slot for one level of the held address.
	function automatic logic [63:0] slot_offset(input logic [1:0] lvl);
		return {52'b0, held_va[OFFSET_W + VPN_W * lvl +: VPN_W], 3'b000};
	endfunction

	// Advance the shadow walker by one input beat; return 1 when a result is due.
	function automatic bit translate_beat(input logic op, input logic [63:0] va,
			input logic [63:0] pte, output walk_beat_t res);
		res.kind    = KIND_FAULT;
		res.address = '0;
		if (op == OP_REQUEST) begin
			// a new request during a walk is swallowed
			if (walk_busy)
				return 1'b0;
			if (addr_mode == MODE_DIRECT) begin
				res.kind    = KIND_DIRECT;
				res.address = va;
				return 1'b1;
			end
			if (addr_mode == MODE_SV39 || addr_mode == MODE_SV39_ALT) begin
				walk_busy   = 1'b1;
				walk_level  = LEVEL_ROOT;
				held_va     = va[HELD_VA_W-1:0];
				res.kind    = KIND_READ;
				res.address = {8'b0, root_page, 12'b0} + slot_offset(LEVEL_ROOT);
			end
			// any other mode leaves the fault in place
			return 1'b1;
		end
		// a response with no walk under way is swallowed
		if (!walk_busy)
			return 1'b0;
		if (!pte[0]) begin
			walk_busy  = 1'b0;
			walk_level = LEVEL_LEAF;
			return 1'b1;
		end
		if (walk_level != LEVEL_LEAF) begin
			walk_level  = walk_level - 2'd1;
			res.kind    = KIND_READ;
			res.address = ((pte & ENTRY_PPN_MASK) << 2) + slot_offset(walk_level);
			return 1'b1;
		end
		walk_busy   = 1'b0;
		res.kind    = KIND_DONE;
		res.address = ((pte & ENTRY_PPN_MASK) << 2) | held_va[OFFSET_W-1:0];
		return 1'b1;
	endfunction

	// Drive one input beat from a falling edge, after a random bubble unless no_stall
	// is set, hold it until taken, and record what it should produce. Return at the
	// next falling edge with valid still high, so back-to-back beats leave no bubble.
	task automatic send_beat(input logic op, input logic [63:0] va, input logic [63:0] pte,
			output bit answered);
		walk_beat_t res;
		if (!no_stall && $urandom_range(99) < IDLE_PCT) begin
			walk_in.valid <= 1'b0;
			@(negedge clk);
		end
		walk_in.valid           <= 1'b1;
		walk_in.mode            <= op;
		walk_in.virtual_address <= va;
		walk_in.entry_data      <= pte;
		do @(posedge clk); while (!walk_in.ready);
		answered = translate_beat(op, va, pte, res);
		if (answered)
			expected_results.push_back(res);
		@(negedge clk);
	endtask

	// Write one register; upper data bits are random so that masking is exercised.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		@(negedge clk);
		walk_cfg.valid <= 1'b1;
		walk_cfg.index <= idx;
		walk_cfg.data  <= value;
		do @(posedge clk); while (!walk_cfg.ready);
		if (idx == REG_ROOT_PAGE)
			root_page = value[ROOT_W-1:0];
		else if (idx == REG_ADDR_MODE)
			addr_mode = value[MODE_W-1:0];
		@(negedge clk);
		walk_cfg.valid <= 1'b0;
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] m);
		write_register(REG_ADDR_MODE, (rand64() & ~64'hf) | 64'(m));
	endtask

	task automatic write_root(input logic [ROOT_W-1:0] r);
		write_register(REG_ROOT_PAGE, {(VA_W - ROOT_W)'(rand64()), r});
	endtask

	// Bring the walker to rest: abort any walk with an invalid entry, drop
	// valid, wait for every result and let swallowed beats clear the pipe.
	task automatic quiesce();
		bit answered;
		if (walk_busy)
			send_beat(OP_RESPONSE, rand64(), rand64() & ~64'h1, answered);
		walk_in.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Direct mode returns the address untouched; a stray response is dropped.
	task automatic test_direct_bypass();
		bit answered;
		quiesce();
		write_mode(MODE_DIRECT);
		write_root(ROOT_MAX);
		send_beat(OP_REQUEST, 64'h0, rand64(), answered);
		send_beat(OP_REQUEST, '1, rand64(), answered);
		send_beat(OP_RESPONSE, rand64(), '1, answered);
		send_beat(OP_REQUEST, 64'haaaa_aaaa_aaaa_aaaa, rand64(), answered);
		send_beat(OP_REQUEST, 64'h5555_5555_5555_5555, rand64(), answered);
	endtask

	// Unknown address modes fault at once without starting a walk.
	task automatic test_unknown_modes();
		logic [MODE_W-1:0] odd_modes[4] = '{4'd1, 4'd7, 4'd10, 4'd15};
		bit answered;
		foreach (odd_modes[i]) begin
			quiesce();
			write_mode(odd_modes[i]);
			send_beat(OP_REQUEST, rand64(), rand64(), answered);
		end
	endtask

	// Full walks at the extremes, a request during a walk, and invalid entries
	// at the root and at the leaf.
	task automatic test_walk_levels();
		bit answered;
		quiesce();
		write_root(ROOT_MAX);
		write_mode(MODE_SV39);
		send_beat(OP_REQUEST, '1, rand64(), answered);
		send_beat(OP_RESPONSE, rand64(), '1, answered);
		send_beat(OP_REQUEST, rand64(), rand64(), answered);
		send_beat(OP_RESPONSE, rand64(), '1, answered);
		send_beat(OP_RESPONSE, rand64(), '1, answered);
		send_beat(OP_REQUEST, rand64(), rand64(), answered);
		send_beat(OP_RESPONSE, rand64(), ~64'h1, answered);
		quiesce();
		write_root('0);
		write_mode(MODE_SV39_ALT);
		send_beat(OP_REQUEST, 64'h0, 64'h0, answered);
		repeat (3) send_beat(OP_RESPONSE, 64'h0, 64'h1, answered);
		send_beat(OP_REQUEST, rand64(), rand64(), answered);
		send_beat(OP_RESPONSE, rand64(), rand64() | 64'h1, answered);
		send_beat(OP_RESPONSE, rand64(), rand64() | 64'h1, answered);
		send_beat(OP_RESPONSE, rand64(), rand64() & ~64'h1, answered);
	endtask

	// One setting of the registers, then random traffic until enough results
	// have been predicted. Walks mostly run to the leaf; noise is mixed in.
	task automatic run_phase(input logic [ROOT_W-1:0] r, input logic [MODE_W-1:0] m,
			input int unsigned results_wanted, input bit steady);
		int unsigned produced;
		int unsigned pick;
		bit          answered;
		quiesce();
		write_root(r);
		write_mode(m);
		no_stall = steady;
		produced = 0;
		while (produced < results_wanted) begin
			pick = $urandom_range(99);
			if (!walk_busy && pick < 8)
				send_beat(OP_RESPONSE, rand64(), rand64(), answered);
			else if (!walk_busy)
				send_beat(OP_REQUEST, rand64(), rand64(), answered);
			else if (pick < 5)
				send_beat(OP_REQUEST, rand64(), rand64(), answered);
			else
				send_beat(OP_RESPONSE, rand64(),
					(rand64() & ~64'h1) | 64'($urandom_range(99) < 90), answered);
			if (answered)
				produced++;
		end
		no_stall = 1'b0;
	endtask

	task automatic test_random_traffic();
		run_phase('0, MODE_SV39, 120, 1'b0);
		run_phase(ROOT_MAX, MODE_SV39_ALT, 120, 1'b0);
		run_phase(ROOT_W'(rand64()), MODE_SV39, 120, 1'b1);   // back-to-back, no stalls
		run_phase(ROOT_W'(rand64()), MODE_DIRECT, 60, 1'b0);
		run_phase(ROOT_W'(rand64()), MODE_W'($urandom_range(15)), 60, 1'b0);
		run_phase(ROOT_W'(rand64()), MODE_SV39_ALT, 120, 1'b0);
		run_phase(ROOT_W'(rand64()), MODE_SV39, 100, 1'b0);
	endtask

	// Result side: stall with a chance of IDLE_PCT in a hundred unless a steady phase runs.
	always @(negedge clk)
		walk_out.ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);

	// Compare every result beat with the oldest prediction.
	always @(posedge clk) begin : check_results
		walk_beat_t want;
		if (arst_n && walk_out.valid && walk_out.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected: kind %0d address %h",
					$time, walk_out.kind, walk_out.address);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (walk_out.kind !== want.kind) begin
					$display("%0t: kind expected %0d actual %0d",
						$time, want.kind, walk_out.kind);
					mismatches++;
				end
				if (walk_out.address !== want.address) begin
					$display("%0t: address expected %h actual %h",
						$time, want.address, walk_out.address);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run once no beat has moved on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (walk_in.valid && walk_in.ready) || (walk_out.valid && walk_out.ready)
				|| (walk_cfg.valid && walk_cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		clk                     = 1'b0;
		arst_n                  = 1'b0;
		walk_in.valid           = 1'b0;
		walk_in.mode            = OP_REQUEST;
		walk_in.virtual_address = '0;
		walk_in.entry_data      = '0;
		walk_out.ready          = 1'b0;
		walk_cfg.valid          = 1'b0;
		walk_cfg.index          = REG_ROOT_PAGE;
		walk_cfg.data           = '0;
		no_stall                = 1'b0;
		mismatches              = 0;
		quiet_cycles            = 0;
		// shadow state matches the walker's reset values
		root_page  = '0;
		addr_mode  = MODE_DIRECT;
		walk_busy  = 1'b0;
		walk_level = LEVEL_LEAF;
		held_va    = '0;

		// hold reset, then release it on a falling edge
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_direct_bypass();
		test_unknown_modes();
		test_walk_levels();
		test_random_traffic();

		// drain: drop valid, wait out every result, then the pipe latency
		walk_in.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES + 1) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ sv39_page_table_walker.f @@
hdl/sv39ptw_pkg.sv
hdl/sv39ptw_ifs.sv
hdl/sv39ptw_step.sv
hdl/sv39_page_table_walker.sv
tb/sv/sv39_page_table_walker_test.sv
